>>> design/pgcc_pkg.sv
// Package: constants, tile decode helpers and shared types for the pipe grid counter.
package pgcc_pkg;
  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxLabelsDef = 4096;
  localparam int unsigned TileW  = 3;
  localparam int unsigned WidthW = 11;
  localparam int unsigned HeightW = 16;
  localparam int unsigned CountW = 26;
  localparam int unsigned CfgW   = 16;

  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    TILE_A = 3'd0, TILE_B = 3'd1, TILE_C = 3'd2, TILE_D = 3'd3,
    TILE_E = 3'd4, TILE_F = 3'd5, TILE_X = 3'd6, TILE_Y = 3'd7
  } tile_e;

  typedef struct packed {
    logic node;
    logic opens_right;
    logic accepts_left;
    logic opens_down;
    logic accepts_up;
  } tile_t;

  function automatic tile_t decode_tile(input logic [TileW-1:0] t);
    tile_t r;
    r = '0;
    case (tile_e'(t))
      TILE_B: r = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
      TILE_C: r = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
      TILE_D: r = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
      TILE_E: r = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
      TILE_F: r = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

>>> design/pgcc_if.sv
// Valid/ready channel interface carrying a word of parameterized width.
interface pgcc_if #(parameter int unsigned W = 1) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/pgcc_parent_mem.sv
// Parent table memory: one write port, one registered read port.
module pgcc_parent_mem #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned AW = $clog2(Depth)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [AW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [AW-1:0] rdata_o
);
  logic [AW-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> design/pgcc_row_mem.sv
// Row store: label and opens-down bit per column, registered read.
module pgcc_row_mem #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned CW = $clog2(Depth),
  parameter int unsigned LW = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [CW-1:0] waddr_i,
  input  logic [LW:0]   wdata_i,
  input  logic [CW-1:0] raddr_i,
  output logic [LW:0]   rdata_o
);
  logic [LW:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> design/pipe_grid_component_counter_core.sv
// Pipe grid component counter: raster union-find with a shared parent memory port.
// Usage: words on in_ch carry one tile code each, in raster order over a grid whose
// size is set by cfg writes (index 0 width, index 1 height). Any config write
// starts a new grid. After the last tile one word leaves on out_ch with the
// component count and a label overflow flag; other tiles give no word.
// Timing: a tile with no union-find work goes from accept through S_RD back to
// S_IDLE; each parent read of a root lookup adds a pass through S_FA and S_FAW
// (or S_FB and S_FBW); a merge adds no state. The last tile of a grid also passes
// through S_DONE, and stays there while an older result waits.
// Lookup chains are short in raster order since larger roots link under
// smaller ones. The result word sits in an output register; a tile is taken
// while it waits, but the next result is held back until it is taken.
// Reset: position, count, allocator and flag clear; grid is 1x1. The row and
// parent memories need no clearing: every read follows a write in use.
module pipe_grid_component_counter_core
  import pgcc_pkg::*;
#(
  parameter int unsigned MaxWidth  = MaxWidthDef,
  parameter int unsigned MaxLabels = MaxLabelsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  pgcc_if.sink                      in_ch,
  pgcc_if.source                    out_ch,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [CfgW-1:0]           cfg_data_i
);
  localparam int unsigned CW = $clog2(MaxWidth);
  localparam int unsigned LW = $clog2(MaxLabels);
  localparam int unsigned MwW = $clog2(MaxWidth + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RD    = 7'b0000010,
    S_FA    = 7'b0000100,
    S_FAW   = 7'b0001000,
    S_FB    = 7'b0010000,
    S_FBW   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  logic [CW-1:0]      col_q;
  logic [HeightW-1:0] row_q;
  logic [LW-1:0]      left_q;
  logic               lor_q;
  logic [LW:0]        nfree_q;
  logic [CountW:0]    cnt_q;
  logic               ovf_q;
  tile_t              t_q;
  logic [LW-1:0]      a_q, b_q, cur_q;
  logic               jl_q, ju_q;
  logic               ov_q;
  logic [CountW-1:0]  oc_q;
  logic               oo_q;

  logic [LW-1:0] p_raddr, p_rdata, p_waddr, p_wdata;
  logic          p_we;
  logic [LW:0]   r_wdata, r_rdata;
  logic          r_we;

  logic [MwW-1:0]     w_eff;
  logic [HeightW-1:0] h_eff;
  logic [CW-1:0]      col_eff;
  logic               last_col, last_row;
  logic               in_acc;
  tile_t              td;
  logic               ju_now;

  always_comb begin
    if (width_q == '0) w_eff = MwW'(1);
    else if (32'(width_q) > MaxWidth) w_eff = MwW'(MaxWidth);
    else w_eff = MwW'(width_q);
    h_eff = (height_q == '0) ? HeightW'(1) : height_q;
    col_eff = (MwW'(col_q) >= w_eff) ? CW'(w_eff - MwW'(1)) : col_q;
    last_col = (MwW'(col_eff) + MwW'(1) >= w_eff);
    last_row = (17'(row_q) + 17'd1 >= 17'(h_eff));
  end

  assign td = decode_tile(in_ch.data);
  assign in_ch.ready = (state_q == S_IDLE) && !cfg_we_i;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign out_ch.valid = ov_q;
  assign out_ch.data = {oc_q, oo_q};

  // up join needs the row read, available in S_RD
  assign ju_now = (row_q != '0) && r_rdata[LW] && t_q.accepts_up;

  pgcc_row_mem #(.Depth(MaxWidth), .CW(CW), .LW(LW)) u_row (
    .clk_i, .we_i(r_we), .waddr_i(col_eff), .wdata_i(r_wdata),
    .raddr_i(col_eff), .rdata_o(r_rdata)
  );
  pgcc_parent_mem #(.Depth(MaxLabels), .AW(LW)) u_par (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .raddr_i(p_raddr), .rdata_o(p_rdata)
  );

  // lookup: S_FA/S_FB issue read of cur, S_FAW/S_FBW check parent
  logic [LW-1:0] lab;
  logic          alloc, merge, fin;
  logic [LW-1:0] up_lab;
  always_comb begin
    state_d = state_q;
    p_raddr = cur_q;
    p_we = 1'b0;
    p_waddr = '0;
    p_wdata = '0;
    alloc = 1'b0;
    merge = 1'b0;
    fin = 1'b0;
    lab = a_q;
    up_lab = r_rdata[LW-1:0];
    case (state_q)
      S_IDLE: if (in_acc) state_d = S_RD;
      S_RD: begin
        if (!t_q.node) begin
          fin = 1'b1;
        end else if (jl_q) begin
          state_d = S_FA;
        end else if (ju_now) begin
          state_d = S_FB;
        end else begin
          alloc = 1'b1;
          fin = 1'b1;
        end
      end
      S_FA: state_d = S_FAW;
      S_FAW: begin
        if (p_rdata < cur_q) state_d = S_FA;
        else if (ju_q) state_d = S_FB;
        else begin
          lab = cur_q;
          fin = 1'b1;
        end
      end
      S_FB: state_d = S_FBW;
      S_FBW: begin
        if (p_rdata < cur_q) state_d = S_FB;
        else if (!jl_q || a_q == cur_q) begin
          lab = cur_q;
          fin = 1'b1;
        end else begin
          merge = 1'b1;
          fin = 1'b1;
          p_we = 1'b1;
          if (a_q < cur_q) begin
            p_waddr = cur_q; p_wdata = a_q; lab = a_q;
          end else begin
            p_waddr = a_q; p_wdata = cur_q; lab = cur_q;
          end
        end
      end
      S_DONE: if (!ov_q || out_ch.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    if (alloc) begin
      lab = (nfree_q < (LW+1)'(MaxLabels)) ? nfree_q[LW-1:0] : LW'(MaxLabels - 1);
      p_we = 1'b1;
      p_waddr = lab;
      p_wdata = lab;
    end
    if (fin) state_d = (last_col && last_row) ? S_DONE : S_IDLE;
    r_we = fin;
    r_wdata = t_q.node ? {t_q.opens_down, lab} : {1'b0, up_lab};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      width_q <= WidthW'(1);
      height_q <= HeightW'(1);
      col_q <= '0;
      row_q <= '0;
      left_q <= '0;
      lor_q <= 1'b0;
      nfree_q <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
      ov_q <= 1'b0;
      t_q <= '0;
      a_q <= '0;
      cur_q <= '0;
      jl_q <= 1'b0;
      ju_q <= 1'b0;
      oc_q <= '0;
      oo_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_WIDTH: width_q <= cfg_data_i[WidthW-1:0];
          CFG_HEIGHT: height_q <= cfg_data_i;
          default: width_q <= width_q;
        endcase
        col_q <= '0; row_q <= '0; left_q <= '0; lor_q <= 1'b0;
        nfree_q <= '0; cnt_q <= '0; ovf_q <= 1'b0;
      end
      if (state_q == S_RD) begin
        a_q <= left_q;
        ju_q <= ju_now;
        if (!jl_q && ju_now) cur_q <= r_rdata[LW-1:0];
        else cur_q <= left_q;
      end
      if (state_q == S_FAW) begin
        if (p_rdata < cur_q) cur_q <= p_rdata;
        else begin
          a_q <= cur_q;
          cur_q <= r_rdata[LW-1:0];
        end
      end
      if (state_q == S_FBW && p_rdata < cur_q) cur_q <= p_rdata;
      if (state_q == S_FA || state_q == S_FB) cur_q <= cur_q;
      if (alloc) begin
        cnt_q <= cnt_q + 1'b1;
        if (nfree_q < (LW+1)'(MaxLabels)) nfree_q <= nfree_q + 1'b1;
        else ovf_q <= 1'b1;
      end
      if (merge && cnt_q != '0) cnt_q <= cnt_q - 1'b1;
      if (fin) begin
        if (t_q.node) begin
          left_q <= lab;
          lor_q <= t_q.opens_right && !last_col;
        end else begin
          lor_q <= 1'b0;
        end
        if (!last_col) col_q <= col_eff + 1'b1;
        else begin
          col_q <= '0;
          if (!last_row) row_q <= row_q + 1'b1;
        end
      end
      if (state_q == S_DONE && state_d == S_IDLE) begin
        ov_q <= 1'b1;
        oc_q <= cnt_q[CountW-1:0];
        oo_q <= ovf_q;
        col_q <= '0; row_q <= '0; left_q <= '0; lor_q <= 1'b0;
        nfree_q <= '0; cnt_q <= '0; ovf_q <= 1'b0;
      end else if (ov_q && out_ch.ready) begin
        ov_q <= 1'b0;
      end
      if (in_acc) begin
        t_q <= td;
        jl_q <= (col_eff != '0) && lor_q && td.accepts_left;
        ju_q <= 1'b0;
      end
      if (state_q == S_IDLE && !in_acc) ju_q <= 1'b0;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_RD)
    else $error("tile accept did not start work");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_we |-> (state_q == S_RD || state_q == S_FBW))
    else $error("parent write outside alloc or merge");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ch.ready |=> ov_q && $stable(oc_q))
    else $error("result lost");
endmodule
